>>> hw/rtl/kwco_pkg.sv
// Shared constants, types and helper functions for the keyed wheel character obfuscator.
package kwco_pkg;

    localparam int KeyAreaMaxDefault = 200;
    localparam int StreamWrapDefault = 60;
    localparam int WheelLen          = 77;
    localparam int AreaSmall         = 100;
    localparam int AreaLarge         = 200;

    localparam logic MODE_KEY  = 1'b0;
    localparam logic MODE_TEXT = 1'b1;

    localparam logic [0:0] REG_KEY_AREA_SELECT = 1'b0;

    // Front-to-back queue entry
    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
        logic       key_last;
    } kwco_item_t;

    // Per-round additive constants
    function automatic logic [31:0] md5_k(input logic [5:0] r);
        logic [31:0] k;
        begin
            unique case (r)
                6'd0:  k = 32'hd76aa478; 6'd1:  k = 32'he8c7b756;
                6'd2:  k = 32'h242070db; 6'd3:  k = 32'hc1bdceee;
                6'd4:  k = 32'hf57c0faf; 6'd5:  k = 32'h4787c62a;
                6'd6:  k = 32'ha8304613; 6'd7:  k = 32'hfd469501;
                6'd8:  k = 32'h698098d8; 6'd9:  k = 32'h8b44f7af;
                6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
                6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
                6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
                6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
                6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
                6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
                6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
                6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
                6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
                6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
                6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
                6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
                6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
                6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
                6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
                6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
                6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
                6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
                6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
                6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
                6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
                6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
                6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
                6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
                6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
                6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
                6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
            endcase
            return k;
        end
    endfunction

    // Rotate amount of a round
    function automatic logic [4:0] md5_s(input logic [5:0] r);
        logic [4:0] s;
        begin
            unique case ({r[5:4], r[1:0]})
                4'h0: s = 5'd7;  4'h1: s = 5'd12; 4'h2: s = 5'd17; 4'h3: s = 5'd22;
                4'h4: s = 5'd5;  4'h5: s = 5'd9;  4'h6: s = 5'd14; 4'h7: s = 5'd20;
                4'h8: s = 5'd4;  4'h9: s = 5'd11; 4'ha: s = 5'd16; 4'hb: s = 5'd23;
                4'hc: s = 5'd6;  4'hd: s = 5'd10; 4'he: s = 5'd15; default: s = 5'd21;
            endcase
            return s;
        end
    endfunction

    // Message word used by a round
    function automatic logic [3:0] md5_g(input logic [5:0] r);
        logic [3:0] g;
        begin
            unique case (r[5:4])
                2'd0: g = r[3:0];
                2'd1: g = 4'(5 * r[3:0] + 1);
                2'd2: g = 4'(3 * r[3:0] + 5);
                default: g = 4'(7 * r[3:0]);
            endcase
            return g;
        end
    endfunction

endpackage

>>> hw/rtl/kwco_front.sv
// Front part: input acceptance and a two-entry queue toward the back part.
module kwco_front
    import kwco_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  kwco_item_t in_item,
    output logic       q_valid,
    input  logic       q_ready,
    output kwco_item_t q_item
);

    kwco_item_t  slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    logic        pop;

    assign in_ready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= 2'(count_reg + {1'b0, push} - {1'b0, pop});
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == 2'd2 |-> !push || pop)
        else $error("queue overflow");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != 2'd0)
        else $error("pop from empty queue");

endmodule

>>> hw/rtl/kwco_md5.sv
// Iterative MD5 compression core: one round per cycle over a 16-word block.
module kwco_md5
    import kwco_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic         first_block,
    input  logic [511:0] block,
    output logic         done,
    output logic [127:0] state
);

    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] h0_reg, h1_reg, h2_reg, h3_reg;
    logic [5:0]  round_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [511:0] blk_reg;
    logic [31:0] f;
    logic [31:0] t;
    logic [31:0] m;
    logic [31:0] rot;
    logic [63:0] dbl;
    logic [31:0] ia, ib, ic, id;

    assign ia = first_block ? 32'h67452301 : h0_reg;
    assign ib = first_block ? 32'hefcdab89 : h1_reg;
    assign ic = first_block ? 32'h98badcfe : h2_reg;
    assign id = first_block ? 32'h10325476 : h3_reg;

    // Round function
    always_comb
    begin
        unique case (round_reg[5:4])
            2'd0: f = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1: f = (d_reg & b_reg) | (~d_reg & c_reg);
            2'd2: f = b_reg ^ c_reg ^ d_reg;
            default: f = c_reg ^ (b_reg | ~d_reg);
        endcase
        m   = blk_reg[32 * md5_g(round_reg) +: 32];
        t   = f + a_reg + md5_k(round_reg) + m;
        dbl = {t, t} << md5_s(round_reg);
        rot = dbl[63:32];
    end

    assign done  = done_reg;
    assign state = {h3_reg, h2_reg, h1_reg, h0_reg};

    // Hold chaining values and step rounds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                round_reg <= 6'd0;
            end
            else if (busy_reg)
            begin
                round_reg <= 6'(round_reg + 6'd1);
                if (round_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            blk_reg <= block;
            a_reg <= ia; b_reg <= ib; c_reg <= ic; d_reg <= id;
            h0_reg <= ia; h1_reg <= ib; h2_reg <= ic; h3_reg <= id;
        end
        else if (busy_reg)
        begin
            if (round_reg == 6'd63)
            begin
                h0_reg <= h0_reg + d_reg;
                h1_reg <= h1_reg + b_reg + rot;
                h2_reg <= h2_reg + b_reg;
                h3_reg <= h3_reg + c_reg;
            end
            a_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= b_reg;
            b_reg <= b_reg + rot;
        end
    end

endmodule

>>> hw/rtl/kwco_back.sv
// Back part: key loading, digest derivation and text byte mapping.
module kwco_back
    import kwco_pkg::*;
#(
    parameter int KEY_AREA_MAX = KeyAreaMaxDefault,
    parameter int STREAM_WRAP  = StreamWrapDefault
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       area_select,
    input  logic       q_valid,
    output logic       q_ready,
    input  kwco_item_t q_item,
    output logic       o_valid,
    input  logic       o_ready,
    output logic [7:0] o_byte,
    output logic       o_end
);

    typedef enum logic [2:0] {
        ST_RUN, ST_CLEAR, ST_LOAD, ST_HASH, ST_STORE
    } state_t;

    localparam int DigCount = 4;

    state_t      state_reg;
    logic [7:0]  area_mem [KEY_AREA_MAX];
    logic [8:0]  fill_reg;
    logic        fill_full;
    logic [7:0]  clr_reg;
    logic [7:0]  dig_mem [64];
    logic [7:0]  dig_rd_reg;
    logic [7:0]  kb_reg;
    logic        key_loaded_reg;
    logic [5:0]  pos_next;
    logic [5:0]  pos_reg;
    logic [1:0]  dig_idx_reg;
    logic [2:0]  blk_idx_reg;
    logic [2:0]  blk_cnt_reg;
    logic [5:0]  word_reg;
    logic [7:0]  rd_addr_reg;
    logic [7:0]  rd_data_reg;
    logic        rd_pend_reg;
    logic [5:0]  rd_word_reg;
    logic [511:0] blk_buf_reg;
    logic [8:0]  msg_len;
    logic        md5_start_reg;
    logic        md5_first_reg;
    logic        md5_done;
    logic [127:0] md5_state;
    logic        o_valid_reg;
    logic [7:0]  o_byte_reg;
    logic        o_end_reg;
    logic        take;
    logic [7:0]  kb;
    logic [6:0]  widx;
    logic        on_wheel;
    logic [7:0]  sum;
    logic [6:0]  mapped;
    logic [7:0]  mapped_ch;
    logic [7:0]  src_byte;
    logic [8:0]  abs_byte;
    logic [63:0] len_bits;

    kwco_md5 u_md5 (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (md5_start_reg),
        .first_block (md5_first_reg),
        .block       (blk_buf_reg),
        .done        (md5_done),
        .state       (md5_state)
    );

    assign fill_full = (fill_reg >= 9'(KEY_AREA_MAX));
    assign q_ready   = (state_reg == ST_RUN) && (!o_valid_reg || o_ready);
    assign take      = q_valid && q_ready;
    assign o_valid   = o_valid_reg;
    assign o_byte    = o_byte_reg;
    assign o_end     = o_end_reg;

    // Message length of the digest in progress
    always_comb
    begin
        unique case (dig_idx_reg)
            2'd0: msg_len = area_select ? 9'(AreaLarge) : 9'(AreaSmall);
            2'd1: msg_len = 9'd16;
            default: msg_len = 9'd32;
        endcase
        len_bits = {52'd0, msg_len, 3'd0};
    end

    // Stream position after this cycle, used to prefetch the key byte
    always_comb
    begin
        pos_next = pos_reg;
        if (take && q_item.mode == MODE_TEXT)
        begin
            if (q_item.data_byte == 8'd0)
                pos_next = 6'd0;
            else
                pos_next = (pos_reg >= 6'(STREAM_WRAP)) ? 6'd0 : 6'(pos_reg + 6'd1);
        end
        else if (take && q_item.key_last)
            pos_next = 6'd0;
    end

    // Wheel lookup
    always_comb
    begin
        kb = key_loaded_reg ? kb_reg : 8'd0;
        on_wheel = 1'b1;
        widx = 7'd0;
        if (q_item.data_byte >= "0" && q_item.data_byte <= "9")
            widx = 7'(q_item.data_byte - "0");
        else if (q_item.data_byte >= "A" && q_item.data_byte <= "Z")
            widx = 7'(q_item.data_byte - "A" + 8'd10);
        else if (q_item.data_byte >= "a" && q_item.data_byte <= "z")
            widx = 7'(q_item.data_byte - "a" + 8'd36);
        else if (q_item.data_byte >= "!" && q_item.data_byte <= "/")
            widx = 7'(q_item.data_byte - "!" + 8'd62);
        else
            on_wheel = 1'b0;
        // idx + kb < 332: up to four subtractions of 77
        abs_byte = {2'b0, widx} + {1'b0, kb};
        if (abs_byte >= 9'd231)      abs_byte = abs_byte - 9'd231;
        else if (abs_byte >= 9'd154) abs_byte = abs_byte - 9'd154;
        else if (abs_byte >= 9'd77)  abs_byte = abs_byte - 9'd77;
        if (abs_byte >= 9'd77)       abs_byte = abs_byte - 9'd77;
        mapped = abs_byte[6:0];
        sum = {1'b0, mapped};
        if (mapped < 7'd10)      mapped_ch = "0" + sum;
        else if (mapped < 7'd36) mapped_ch = "A" + sum - 8'd10;
        else if (mapped < 7'd62) mapped_ch = "a" + sum - 8'd36;
        else                     mapped_ch = "!" + sum - 8'd62;
    end

    // Source byte for the block being built
    always_comb
    begin
        unique case (dig_idx_reg)
            2'd0: src_byte = rd_data_reg;
            default: src_byte = dig_rd_reg;
        endcase
    end

    // Key area writes and registered read
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
            area_mem[clr_reg] <= 8'd0;
        else if (take && q_item.mode == MODE_KEY && !fill_full && q_item.data_byte != 8'd0)
            area_mem[fill_reg[7:0]] <= q_item.data_byte;
        rd_data_reg <= area_mem[rd_addr_reg];
    end

    // Digest store: one byte written per cycle, registered reads
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_STORE)
            dig_mem[{dig_idx_reg, word_reg[3:0]}] <= md5_state[8 * word_reg[3:0] +: 8];
        dig_rd_reg <= dig_mem[rd_word_reg];
        kb_reg     <= dig_mem[pos_next];
    end

    // Control and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= 8'd0;
            fill_reg       <= 9'd0;
            pos_reg        <= 6'd0;
            o_valid_reg    <= 1'b0;
            md5_start_reg  <= 1'b0;
            md5_first_reg  <= 1'b0;
            rd_pend_reg    <= 1'b0;
            dig_idx_reg    <= 2'd0;
            blk_idx_reg    <= 3'd0;
            blk_cnt_reg    <= 3'd0;
            word_reg       <= 6'd0;
            rd_addr_reg    <= 8'd0;
            rd_word_reg    <= 6'd0;
            o_byte_reg     <= 8'd0;
            o_end_reg      <= 1'b0;
            key_loaded_reg <= 1'b0;
        end
        else
        begin
            md5_start_reg <= 1'b0;
            if (o_valid_reg && o_ready)
                o_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= 8'(clr_reg + 8'd1);
                    if (clr_reg == 8'(KEY_AREA_MAX - 1))
                    begin
                        clr_reg  <= 8'd0;
                        fill_reg <= 9'd0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (take && q_item.mode == MODE_TEXT)
                    begin
                        o_valid_reg <= 1'b1;
                        if (q_item.data_byte == 8'd0)
                        begin
                            o_byte_reg <= 8'd0;
                            o_end_reg  <= 1'b1;
                            pos_reg    <= 6'd0;
                        end
                        else
                        begin
                            o_byte_reg <= on_wheel ? mapped_ch : q_item.data_byte;
                            o_end_reg  <= 1'b0;
                            pos_reg <= (pos_reg >= 6'(STREAM_WRAP)) ? 6'd0
                                                                    : 6'(pos_reg + 6'd1);
                        end
                    end
                    else if (take)
                    begin
                        if (!fill_full)
                            fill_reg <= (q_item.data_byte == 8'd0) ? 9'(KEY_AREA_MAX)
                                                                   : 9'(fill_reg + 9'd1);
                        if (q_item.key_last)
                        begin
                            dig_idx_reg <= 2'd0;
                            blk_idx_reg <= 3'd0;
                            blk_cnt_reg <= area_select ? 3'd4 : 3'd2;
                            word_reg    <= 6'd0;
                            rd_addr_reg <= 8'd0;
                            rd_word_reg <= 6'd0;
                            rd_pend_reg <= 1'b0;
                            pos_reg     <= 6'd0;
                            state_reg   <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD:
                begin
                    // Fill the 64-byte block one byte at a time: issue the read, then write the byte
                    if (!rd_pend_reg)
                    begin
                        rd_pend_reg <= 1'b1;
                    end
                    else
                    begin
                        if (({3'd0, blk_idx_reg, word_reg}) < msg_len)
                        begin
                            if (dig_idx_reg == 2'd0
                                && {1'b0, rd_addr_reg} >= 9'(KEY_AREA_MAX))
                                blk_buf_reg[8 * word_reg +: 8] <= 8'd0;
                            else
                                blk_buf_reg[8 * word_reg +: 8] <= src_byte;
                        end
                        else if (({3'd0, blk_idx_reg, word_reg}) == msg_len)
                            blk_buf_reg[8 * word_reg +: 8] <= 8'h80;
                        else if (blk_idx_reg == 3'(blk_cnt_reg - 3'd1) && word_reg >= 6'd56)
                            blk_buf_reg[8 * word_reg +: 8] <= len_bits[8 * word_reg[2:0] +: 8];
                        else
                            blk_buf_reg[8 * word_reg +: 8] <= 8'd0;
                        rd_pend_reg <= 1'b0;
                        rd_addr_reg <= 8'(rd_addr_reg + 8'd1);
                        rd_word_reg <= 6'(rd_word_reg + 6'd1);
                        word_reg    <= 6'(word_reg + 6'd1);
                        if (word_reg == 6'd63)
                        begin
                            md5_start_reg <= 1'b1;
                            md5_first_reg <= (blk_idx_reg == 3'd0);
                            state_reg     <= ST_HASH;
                        end
                    end
                end
                ST_HASH:
                begin
                    if (md5_done)
                    begin
                        if (blk_idx_reg == 3'(blk_cnt_reg - 3'd1))
                            state_reg <= ST_STORE;
                        else
                        begin
                            blk_idx_reg <= 3'(blk_idx_reg + 3'd1);
                            state_reg   <= ST_LOAD;
                        end
                    end
                end
                ST_STORE:
                begin
                    // Write the digest out one byte per cycle
                    word_reg <= 6'(word_reg + 6'd1);
                    if (word_reg == 6'd15)
                    begin
                        dig_idx_reg <= 2'(dig_idx_reg + 2'd1);
                        blk_idx_reg <= 3'd0;
                        blk_cnt_reg <= (dig_idx_reg == 2'd0) ? 3'd1 : 3'd1;
                        word_reg    <= 6'd0;
                        rd_addr_reg <= 8'd0;
                        rd_word_reg <= 6'd0;
                        rd_pend_reg <= 1'b0;
                        if (dig_idx_reg == 2'(DigCount - 1))
                        begin
                            key_loaded_reg <= 1'b1;
                            state_reg      <= ST_CLEAR;
                        end
                        else
                            state_reg <= ST_LOAD;
                    end
                end
                default: state_reg <= ST_CLEAR;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && !o_ready |=> o_valid_reg && $stable(o_byte_reg))
        else $error("result dropped while stalled");
    a_busy_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_RUN |-> !take)
        else $error("item taken while deriving keys");
    a_end_nul: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && o_end_reg |-> o_byte_reg == 8'd0)
        else $error("message end carries nonzero byte");
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= 6'(STREAM_WRAP))
        else $error("stream pointer beyond wrap");

endmodule

>>> hw/rtl/keyed_wheel_char_obfuscator_unit.sv
// Top level of the keyed wheel character obfuscator with its register port.
//
//  channel | dir | handshake              | payload
//  s_axis  | in  | s_axis_tvalid/tready   | tdata[7:0]=data_byte, tuser[0]=mode, tlast=key_last
//  m_axis  | out | m_axis_tvalid/tready   | tdata[7:0]=out_byte, tlast=message_end
//  apb     | in  | psel/penable/pready    | reg 0 at 0x0: key_area_select
//
// Text and key bytes are taken back to back unless the output stalls or a key is derived;
// a two-entry queue decouples input from the core. After the last key byte the core hashes
// 5 blocks (100-byte area) or 7 blocks (200-byte area); each block is loaded byte by byte
// (a read, then a write) and hashed, and each of the four digests is stored byte by byte;
// then the key area is cleared, one byte a cycle. After reset the key area is cleared before
// items are taken. Output stalls hold the result register and back up into the queue.
module keyed_wheel_char_obfuscator_unit
    import kwco_pkg::*;
#(
    parameter int KEY_AREA_MAX = KeyAreaMaxDefault,
    parameter int STREAM_WRAP  = StreamWrapDefault
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] mode
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       sel_reg;
    kwco_item_t in_item;
    kwco_item_t q_item;
    logic       q_valid;
    logic       q_ready;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_KEY_AREA_SELECT) ? {31'd0, sel_reg} : 32'd0;

    // Write the configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_reg <= 1'b0;
        else if (psel && penable && pwrite && paddr == REG_KEY_AREA_SELECT)
            sel_reg <= pwdata[0];
    end

    assign in_item.mode      = s_axis_tuser;
    assign in_item.data_byte = s_axis_tdata;
    assign in_item.key_last  = s_axis_tlast;

    kwco_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    kwco_back #(
        .KEY_AREA_MAX (KEY_AREA_MAX),
        .STREAM_WRAP  (STREAM_WRAP)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .area_select (sel_reg),
        .q_valid     (q_valid),
        .q_ready     (q_ready),
        .q_item      (q_item),
        .o_valid     (m_axis_tvalid),
        .o_ready     (m_axis_tready),
        .o_byte      (m_axis_tdata),
        .o_end       (m_axis_tlast)
    );

endmodule

>>> test/kwco_scoreboard.sv
// Checker that predicts the obfuscator's output bytes and compares them with the output stream.
module kwco_scoreboard
    import kwco_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] mode
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    input  logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] out_byte;
        logic       message_end;
    } enc_result_t;

    typedef logic [7:0] byte_buf_t [256];
    typedef logic [7:0] digest_t [16];

    enc_result_t    enc_q[$];
    logic [7:0]     key_bytes [256];
    logic [7:0]     key_digests [64];
    int             key_fill;
    int             key_ptr;
    logic           area_sel;
    int             pushed_n;
    int             popped_n;

    // MD5 of the first len bytes of msg
    function automatic digest_t md5_of(input byte_buf_t msg, input int len);
        logic [7:0]  pad [256];
        logic [31:0] h [4];
        logic [31:0] w [16];
        logic [31:0] kt [64];
        int          sh [16];
        logic [31:0] a, b, c, d, f, t;
        logic [63:0] nbits;
        int          total, g;
        real         sv;
        digest_t     dig;
        sh = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
        for (int i = 0; i < 64; i++)
        begin
            sv = $sin(i + 1);
            if (sv < 0.0)
                sv = -sv;
            kt[i] = 32'(longint'($floor(sv * 4294967296.0)));
        end
        for (int i = 0; i < 256; i++)
            pad[i] = (i < len) ? msg[i] : 8'h00;
        pad[len] = 8'h80;
        total = ((len + 8) / 64 + 1) * 64;
        nbits = 64'(len) * 8;
        for (int i = 0; i < 8; i++)
            pad[total - 8 + i] = nbits[8*i +: 8];
        h = '{32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476};
        for (int blk = 0; blk < total; blk += 64)
        begin
            for (int i = 0; i < 16; i++)
                w[i] = {pad[blk+4*i+3], pad[blk+4*i+2], pad[blk+4*i+1], pad[blk+4*i]};
            a = h[0]; b = h[1]; c = h[2]; d = h[3];
            for (int r = 0; r < 64; r++)
            begin
                if (r < 16)
                begin
                    f = (b & c) | (~b & d); g = r;
                end
                else if (r < 32)
                begin
                    f = (d & b) | (~d & c); g = (5 * r + 1) % 16;
                end
                else if (r < 48)
                begin
                    f = b ^ c ^ d; g = (3 * r + 5) % 16;
                end
                else
                begin
                    f = c ^ (b | ~d); g = (7 * r) % 16;
                end
                t = f + a + kt[r] + w[g];
                a = d; d = c; c = b;
                b = b + ((t << sh[(r / 16) * 4 + r % 4]) | (t >> (32 - sh[(r / 16) * 4 + r % 4])));
            end
            h[0] += a; h[1] += b; h[2] += c; h[3] += d;
        end
        for (int i = 0; i < 16; i++)
            dig[i] = h[i / 4][8*(i % 4) +: 8];
        return dig;
    endfunction

    // Rebuild the 64-byte key stream from the current key area
    task automatic derive_stream();
        byte_buf_t src;
        digest_t   dg;
        for (int i = 0; i < 256; i++)
            src[i] = key_bytes[i];
        dg = md5_of(src, area_sel ? AreaLarge : AreaSmall);
        for (int i = 0; i < 16; i++)
            key_digests[i] = dg[i];
        for (int i = 0; i < 256; i++)
            src[i] = (i < 16) ? key_digests[i] : 8'h00;
        dg = md5_of(src, 16);
        for (int i = 0; i < 16; i++)
            key_digests[16 + i] = dg[i];
        for (int i = 0; i < 256; i++)
            src[i] = (i < 32) ? key_digests[i] : 8'h00;
        dg = md5_of(src, 32);
        for (int i = 0; i < 16; i++)
        begin
            key_digests[32 + i] = dg[i];
            key_digests[48 + i] = dg[i];
        end
    endtask

    function automatic int wheel_pos(input logic [7:0] ch);
        if (ch >= "0" && ch <= "9") return ch - "0";
        if (ch >= "A" && ch <= "Z") return 10 + ch - "A";
        if (ch >= "a" && ch <= "z") return 36 + ch - "a";
        if (ch >= "!" && ch <= "/") return 62 + ch - "!";
        return -1;
    endfunction

    function automatic logic [7:0] wheel_sym(input int idx);
        if (idx < 10) return 8'("0" + idx);
        if (idx < 36) return 8'("A" + idx - 10);
        if (idx < 62) return 8'("a" + idx - 36);
        return 8'("!" + idx - 62);
    endfunction

    // Predict each accepted request, compare each accepted output byte
    always @(posedge clk or negedge rst_n)
    begin
        enc_result_t er;
        enc_result_t got;
        int          kb, idx;
        if (!rst_n)
        begin
            enc_q.delete();
            for (int i = 0; i < 256; i++)
                key_bytes[i] = 8'h00;
            for (int i = 0; i < 64; i++)
                key_digests[i] = 8'h00;
            key_fill    = 0;
            key_ptr     = 0;
            area_sel    = 1'b0;
            pushed_n    = 0;
            popped_n    = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // Track register writes
            if (psel && penable && pwrite && pready && paddr == REG_KEY_AREA_SELECT)
                area_sel = pwdata[0];

            // Predict from the input request
            if (s_axis_tvalid && s_axis_tready)
            begin
                if (s_axis_tuser == MODE_KEY)
                begin
                    if (key_fill < KeyAreaMaxDefault)
                    begin
                        if (s_axis_tdata == 8'h00)
                            key_fill = KeyAreaMaxDefault;
                        else
                        begin
                            key_bytes[key_fill] = s_axis_tdata;
                            key_fill++;
                        end
                    end
                    if (s_axis_tlast)
                    begin
                        derive_stream();
                        for (int i = 0; i < 256; i++)
                            key_bytes[i] = 8'h00;
                        key_fill = 0;
                        key_ptr  = 0;
                    end
                end
                else
                begin
                    kb = key_digests[key_ptr];
                    key_ptr = (key_ptr + 1 > StreamWrapDefault) ? 0 : key_ptr + 1;
                    if (s_axis_tdata == 8'h00)
                    begin
                        key_ptr        = 0;
                        er.out_byte    = 8'h00;
                        er.message_end = 1'b1;
                    end
                    else
                    begin
                        idx = wheel_pos(s_axis_tdata);
                        er.out_byte    = (idx >= 0) ? wheel_sym((idx + kb) % WheelLen)
                                                    : s_axis_tdata;
                        er.message_end = 1'b0;
                    end
                    enc_q.push_back(er);
                    pushed_n++;
                end
            end

            // Compare the output request with the oldest prediction
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.out_byte    = m_axis_tdata;
                got.message_end = m_axis_tlast;
                if (enc_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected output: out_byte=%h message_end=%b",
                                 got.out_byte, got.message_end);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    er = enc_q.pop_front();
                    popped_n++;
                    if (er.out_byte !== got.out_byte || er.message_end !== got.message_end)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: exp out_byte=%h message_end=%b, got %h %b",
                                     er.out_byte, er.message_end,
                                     got.out_byte, got.message_end);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            outstanding <= pushed_n - popped_n;
        end
    end

endmodule

>>> test/tb_keyed_wheel_char_obfuscator_unit.sv
// Testbench top: drives key and text bytes and register writes, and gives the verdict.
module tb_keyed_wheel_char_obfuscator_unit
    import kwco_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DeriveWait = 3000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tuser;   // [0] mode
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [7:0] out_byte
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          outstanding;
    int          sent_n;
    logic        quiet;

    keyed_wheel_char_obfuscator_unit u_dut (.*);

    kwco_scoreboard u_scoreboard (
        .clk, .rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .s_axis_tlast, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fail_count, .outstanding
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    // Output side: random stall bursts, none once quiet
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 9) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(20, 80)) @(posedge clk);
        end
    end

    // Send one request and hold it until taken
    task automatic send_byte(input logic mode, input logic [7:0] data, input logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        forever
        begin
            @(negedge clk);
            if (s_axis_tready)
                break;
        end
        @(posedge clk);
        sent_n++;
        if (!quiet && $urandom_range(0, 7) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // Drain all results and let any key derivation finish
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (DeriveWait) @(posedge clk);
    endtask

    task automatic write_area_select(input logic sel);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_KEY_AREA_SELECT;
        pwdata  <= {31'd0, sel};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [7:0] rand_text();
        int idx;
        idx = $urandom_range(0, 76);
        if ($urandom_range(0, 9) < 3)
            return 8'($urandom_range(1, 255));
        if (idx < 10) return 8'("0" + idx);
        if (idx < 36) return 8'("A" + idx - 10);
        if (idx < 62) return 8'("a" + idx - 36);
        return 8'("!" + idx - 62);
    endfunction

    // Key of n bytes, possibly with a NUL inside
    task automatic send_key(input int n);
        int nul_at;
        nul_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n - 1) : -1;
        for (int i = 0; i < n; i++)
            send_byte(MODE_KEY, (i == nul_at) ? 8'h00 : 8'($urandom_range(1, 255)),
                      i == n - 1);
    endtask

    task automatic send_message(input int n);
        for (int i = 0; i < n; i++)
            send_byte(MODE_TEXT, rand_text(), $urandom_range(0, 15) == 0);
        if ($urandom_range(0, 4) != 0)
            send_byte(MODE_TEXT, 8'h00, 1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int klen;
        rst_n         = 1'b0;
        quiet         = 1'b0;
        sent_n        = 0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = MODE_KEY;
        s_axis_tlast  = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = REG_KEY_AREA_SELECT;
        pwdata        = 32'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // No key yet: wheel bytes map to themselves
        send_byte(MODE_TEXT, "0", 1'b0);
        send_byte(MODE_TEXT, "z", 1'b1);
        send_byte(MODE_TEXT, 8'hff, 1'b0);
        send_byte(MODE_TEXT, 8'h00, 1'b0);
        // Short key, small area; then wheel edges and off-wheel bytes
        send_byte(MODE_KEY, 8'h01, 1'b0);
        send_byte(MODE_KEY, 8'hff, 1'b1);
        send_byte(MODE_TEXT, "9", 1'b0);
        send_byte(MODE_TEXT, "A", 1'b0);
        send_byte(MODE_TEXT, "Z", 1'b0);
        send_byte(MODE_TEXT, "a", 1'b0);
        send_byte(MODE_TEXT, "!", 1'b0);
        send_byte(MODE_TEXT, "/", 1'b0);
        send_byte(MODE_TEXT, " ", 1'b0);
        send_byte(MODE_TEXT, 8'h80, 1'b0);
        send_byte(MODE_TEXT, 8'h00, 1'b0);
        // Large area; key with a NUL followed by ignored bytes
        write_area_select(1'b1);
        send_byte(MODE_KEY, "k", 1'b0);
        send_byte(MODE_KEY, 8'h00, 1'b0);
        send_byte(MODE_KEY, "q", 1'b1);
        send_byte(MODE_TEXT, "m", 1'b0);
        send_byte(MODE_TEXT, "7", 1'b0);
        send_byte(MODE_TEXT, 8'h00, 1'b1);
        // Key longer than the area
        send_key(215);
        send_message(70);
        write_area_select(1'b0);

        // Random sessions: key, then messages
        while (sent_n < 650)
        begin
            if (sent_n > 560)
                quiet = 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0)
                write_area_select(1'($urandom_range(0, 1)));
            klen = $urandom_range(1, 30);
            send_key(klen);
            repeat ($urandom_range(1, 3))
                send_message($urandom_range(1, 40));
        end

        drain();
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
